// File: rtl/core/adu_pkg.sv
package adu_pkg;

  // Advertising data types that carry lists of 128-bit service UUIDs.
  localparam logic [7:0] AD_MORE_UUID128     = 8'h06;
  localparam logic [7:0] AD_COMPLETE_UUID128 = 8'h07;

  // Byte positions inside one 16-byte UUID chunk.
  localparam int unsigned  UUID_BYTES = 16;
  localparam logic [3:0]   LAST_CHUNK_BYTE = 4'(UUID_BYTES - 1);

  // Configuration register indexes.
  localparam int unsigned  CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_UUID_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UUID_HIGH = 8'd1;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_LEN  = 5'b00001,
    PH_TYPE = 5'b00010,
    PH_SKIP = 5'b00100,
    PH_UUID = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  // Verdict handed from the parser to the output stage.
  typedef struct packed {
    logic valid;
    logic found;
  } verdict_t;

endpackage

// File: rtl/core/adu_parser.sv
module adu_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_accept,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  input  logic                            cfg_write,
  input  logic [adu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  output adu_pkg::verdict_t               verdict
);
  import adu_pkg::*;

  // Target UUID registers.
  logic [63:0] uuid_low_bytes;
  logic [63:0] uuid_high_bytes;

  // Parse state.
  phase_t      phase;
  logic [7:0]  bytes_left;
  logic [3:0]  chunks_left;
  logic [3:0]  byte_in_chunk;
  logic        chunk_mismatch;
  logic        match_seen;

  phase_t      phase_next;
  logic [7:0]  bytes_left_next;
  logic [3:0]  chunks_left_next;
  logic [3:0]  byte_in_chunk_next;
  logic        chunk_mismatch_next;
  logic        match_seen_next;

  logic [127:0] uuid_all;
  logic [7:0]   target_byte;
  logic         mismatch_now;
  logic [7:0]   bytes_left_dec;
  logic         uuid_type;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      uuid_low_bytes  <= '0;
      uuid_high_bytes <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_UUID_LOW) begin
        uuid_low_bytes <= cfg_data;
      end else if (cfg_index == CFG_UUID_HIGH) begin
        uuid_high_bytes <= cfg_data;
      end
    end
  end

  // Expected byte at the current position of the chunk.
  assign uuid_all       = {uuid_high_bytes, uuid_low_bytes};
  assign target_byte    = uuid_all[{byte_in_chunk, 3'b000} +: 8];
  assign mismatch_now   = chunk_mismatch | (data_byte != target_byte);
  assign bytes_left_dec = bytes_left - 8'd1;
  assign uuid_type      = (data_byte == AD_MORE_UUID128) ||
                          (data_byte == AD_COMPLETE_UUID128);

  // One step of the length-type-value walk for the incoming byte.
  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    chunks_left_next    = chunks_left;
    byte_in_chunk_next  = byte_in_chunk;
    chunk_mismatch_next = chunk_mismatch;
    match_seen_next     = match_seen;

    unique case (phase)
      PH_LEN: begin
        if (data_byte == 8'd0) begin
          phase_next = PH_DONE;
        end else begin
          bytes_left_next = data_byte - 8'd1;
          phase_next      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (uuid_type) begin
          // Only whole 16-byte chunks are compared.
          chunks_left_next    = bytes_left[7:4];
          byte_in_chunk_next  = '0;
          chunk_mismatch_next = 1'b0;
          phase_next          = (bytes_left[7:4] == 4'd0) ? PH_DONE : PH_UUID;
        end else begin
          phase_next = (bytes_left == 8'd0) ? PH_LEN : PH_SKIP;
        end
      end
      PH_SKIP: begin
        bytes_left_next = bytes_left_dec;
        if (bytes_left_dec == 8'd0) begin
          phase_next = PH_LEN;
        end
      end
      PH_UUID: begin
        chunk_mismatch_next = mismatch_now;
        if (byte_in_chunk == LAST_CHUNK_BYTE) begin
          if (!mismatch_now) begin
            match_seen_next = 1'b1;
            phase_next      = PH_DONE;
          end else begin
            chunks_left_next    = chunks_left - 4'd1;
            if (chunks_left == 4'd1) begin
              phase_next = PH_DONE;
            end
            byte_in_chunk_next  = '0;
            chunk_mismatch_next = 1'b0;
          end
        end else begin
          byte_in_chunk_next = byte_in_chunk + 4'd1;
        end
      end
      default: begin
        // The search has ended; bytes are ignored until the report ends.
      end
    endcase
  end

  // Parse state register; the last byte of a report returns it to reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN;
      bytes_left     <= '0;
      chunks_left    <= '0;
      byte_in_chunk  <= '0;
      chunk_mismatch <= 1'b0;
      match_seen     <= 1'b0;
    end else if (in_accept) begin
      if (last_byte) begin
        phase          <= PH_LEN;
        bytes_left     <= '0;
        chunks_left    <= '0;
        byte_in_chunk  <= '0;
        chunk_mismatch <= 1'b0;
        match_seen     <= 1'b0;
      end else begin
        phase          <= phase_next;
        bytes_left     <= bytes_left_next;
        chunks_left    <= chunks_left_next;
        byte_in_chunk  <= byte_in_chunk_next;
        chunk_mismatch <= chunk_mismatch_next;
        match_seen     <= match_seen_next;
      end
    end
  end

  // The verdict goes out in the cycle the last byte is taken.
  assign verdict.valid = in_accept & last_byte;
  assign verdict.found = match_seen_next;

endmodule

// File: rtl/core/adu_out_skid.sv
module adu_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  adu_pkg::verdict_t verdict,
  output logic              space,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata
);
  import adu_pkg::*;

  logic main_valid;
  logic main_found;
  logic skid_valid;
  logic skid_found;

  // Output register backed by one skid entry, so the input side never waits
  // on the receiver's ready in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || m_tready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= verdict.valid;
      end
    end else if (verdict.valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!main_valid || m_tready) begin
      main_found <= skid_valid ? skid_found : verdict.found;
    end
    if (!skid_valid) begin
      skid_found <= verdict.found;
    end
  end

  assign space    = ~skid_valid;
  assign m_tvalid = main_valid;
  assign m_tdata  = {7'd0, main_found};

endmodule

// File: rtl/core/adv_data_uuid128_filter_unit.sv
// Advertising-data 128-bit UUID filter.
// The s_ stream carries one report byte per request: s_tdata is the payload
// byte and s_tlast marks the final byte of the report. The block walks the
// length-type-value structures and compares each whole 16-byte chunk of the
// first 128-bit UUID list structure with the target UUID.
// The target is written on the cfg_ channel: index 0 loads UUID bytes 0 to 7,
// index 1 loads bytes 8 to 15, byte 0 of each in bits 7:0. cfg_ready is
// always high; write only while no report is in progress.
// One m_ request follows each report once its last byte is taken, through
// the output register; m_tdata bit 0 is 1 when the target UUID was found.
// Throughput is one byte per cycle while s_tready is high; the parse state
// updates once per byte. The output register has one skid entry behind it, so
// s_tready drops only when two verdicts are waiting on a stalled receiver.
// Reset clears the parse state, the output stage and both UUID registers.
module adv_data_uuid128_filter_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tlast,   // last_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [0] uuid_found, [7:1] zero
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [adu_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);
  import adu_pkg::*;

  verdict_t verdict;
  logic     space;
  logic     in_accept;

  assign s_tready  = space;
  assign in_accept = s_tvalid & space;
  assign cfg_ready = 1'b1;

  // Per-byte parser and UUID registers.
  adu_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .verdict   (verdict)
  );

  // Result register with skid entry.
  adu_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .verdict  (verdict),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
